// ===== sv/priority_quantum_scheduler_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority quantum scheduler
// Clocked property checks that drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUANTUM_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_QUANTUM_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTH
// Property checked on every rising edge, off while reset is high
`define PQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked on every rising edge, off while reset is high
`define PQS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PQS_ASSERT(lbl, prop, msg)
`define PQS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/pqs_pkg.sv =====
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared sizes, codes and table port types for the priority quantum scheduler.
// ----------------------------------------------------------------------------
package pqs_pkg;

  // Table size and derived widths
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_RAN    = 3'd2,
    ST_IDLE   = 3'd3,
    ST_READ   = 3'd4,
    ST_BADIDX = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_READ,
    S_READ_WAIT,
    S_SCAN,
    S_FETCH,
    S_FETCH_WAIT,
    S_UPDATE,
    S_FINISH,
    S_NOP
  } state_t;

  // Table write controls, one write address shared by all fields
  typedef struct packed {
    logic             we_id;
    logic             we_rem;
    logic             we_prio;
    logic             we_lat;
    logic [IDX_W-1:0] addr;
    logic [15:0]      id;
    logic [15:0]      rem;
    logic [7:0]       prio;
    logic [31:0]      lat;
  } tbl_wr_t;

  // Registered table read data
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] rem;
    logic [7:0]  prio;
    logic [31:0] lat;
  } tbl_rd_t;

endpackage

// ===== sv/pqs_table.sv =====
// ----------------------------------------------------------------------------
// pqs_table
// Process table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pqs_table
  import pqs_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output tbl_rd_t          rd
);

  logic [15:0] ids   [MAX_PROCS];
  logic [15:0] rems  [MAX_PROCS];
  logic [7:0]  prios [MAX_PROCS];
  logic [31:0] lats  [MAX_PROCS];

  // Per-field write
  always_ff @(posedge clk) begin
    if (wr.we_id)   ids[wr.addr]   <= wr.id;
    if (wr.we_rem)  rems[wr.addr]  <= wr.rem;
    if (wr.we_prio) prios[wr.addr] <= wr.prio;
    if (wr.we_lat)  lats[wr.addr]  <= wr.lat;
  end

  // Registered read, all fields at one address
  always_ff @(posedge clk) begin
    rd.id   <= ids[rd_addr];
    rd.rem  <= rems[rd_addr];
    rd.prio <= prios[rd_addr];
    rd.lat  <= lats[rd_addr];
  end

endmodule

// ===== sv/priority_quantum_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_quantum_scheduler_core
// Non-preemptive priority scheduler over a process table with a time quantum.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and its fields with start high while busy is
//   low; the beat is taken on that edge and busy rises on the next cycle.
//   Result channel: done pulses for one cycle with status, out_id,
//   out_remaining and out_latency; the receiver cannot stall, so the beat
//   must be captured in that cycle.
//   Config: quantum_we writes quantum_wdata into the quantum register; write
//   it only while the block is idle.
// Sequencing (N = entries in the table):
//   add and unused command: S_ADD or S_NOP, then done.
//   read: S_READ, then S_READ_WAIT unless the index is out of range.
//   step: a scan pass; if an entry runs, S_FETCH, S_FETCH_WAIT, an update
//   pass and S_FINISH. The single table read port sets this: one pass of
//   N reads finds the winner, a second read-modify-write pass adds the run
//   time to the latency of every entry with nonzero priority.
//   A new command can be accepted in the cycle done is high.
// Reset: synchronous rst empties the table (count zero) and sets quantum to
//   1. Table contents are not cleared; entries at or above the count are
//   never read.
// ----------------------------------------------------------------------------
module priority_quantum_scheduler_core
  import pqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] proc_id,
  input  logic [15:0] run_time,
  input  logic [7:0]  prio,
  input  logic [3:0]  entry_index,
  input  logic        quantum_we,
  input  logic [15:0] quantum_wdata,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] out_id,
  output logic [15:0] out_remaining,
  output logic [31:0] out_latency
);

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [15:0]      quantum;

  // Latched command beat
  cmd_t        cmd_q;
  logic [15:0] id_q;
  logic [15:0] time_q;
  logic [7:0]  prio_q;
  logic [3:0]  idx_q;

  // Sequencer datapath
  logic [CNT_W-1:0] ptr;
  logic             vld;
  logic [IDX_W-1:0] vidx;
  logic [7:0]       best;
  logic [IDX_W-1:0] pos;
  logic [15:0]      run;
  logic [15:0]      id_r;
  logic [15:0]      rem_r;
  logic [31:0]      lat_r;

  tbl_wr_t          wr;
  tbl_rd_t          rd;
  logic [IDX_W-1:0] rd_addr;

  logic        issue;
  logic        pass_end;
  logic        read_bad;
  logic        full;
  logic [15:0] run_calc;
  logic [15:0] rem_calc;
  logic [32:0] lat_sum;
  logic [31:0] lat_sat;

  assign busy     = (state != S_IDLE);
  assign pass_end = (ptr == count) && !vld;
  assign read_bad = int'(idx_q) >= int'(count);
  assign full     = (count == CNT_W'(MAX_PROCS));

  // Shared arithmetic: run slice, remaining time, saturating latency add
  assign run_calc = (quantum > rd.rem) ? rd.rem : quantum;
  assign rem_calc = rd.rem - run_calc;
  assign lat_sum  = {1'b0, rd.lat} + {17'd0, run};
  assign lat_sat  = lat_sum[32] ? '1 : lat_sum[31:0];

  pqs_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table controls
  always_comb begin
    state_next = state;
    wr         = '0;
    rd_addr    = ptr[IDX_W-1:0];
    issue      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(cmd))
            CMD_ADD:  state_next = S_ADD;
            CMD_STEP: state_next = S_SCAN;
            CMD_READ: state_next = S_READ;
            CMD_NOP:  state_next = S_NOP;
          endcase
        end
      end
      S_ADD: begin
        if (!full) begin
          wr.we_id   = 1'b1;
          wr.we_rem  = 1'b1;
          wr.we_prio = 1'b1;
          wr.we_lat  = 1'b1;
          wr.addr    = count[IDX_W-1:0];
          wr.id      = id_q;
          wr.rem     = time_q;
          wr.prio    = prio_q;
          wr.lat     = '0;
        end
        state_next = S_IDLE;
      end
      S_READ: begin
        rd_addr    = IDX_W'(idx_q);
        state_next = read_bad ? S_IDLE : S_READ_WAIT;
      end
      S_READ_WAIT: state_next = S_IDLE;
      S_SCAN: begin
        issue = (ptr < count);
        if (pass_end) begin
          state_next = (best == '0) ? S_IDLE : S_FETCH;
        end
      end
      S_FETCH: begin
        rd_addr    = pos;
        state_next = S_FETCH_WAIT;
      end
      S_FETCH_WAIT: begin
        wr.we_rem  = 1'b1;
        wr.addr    = pos;
        wr.rem     = rem_calc;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        issue = (ptr < count);
        if (vld && rd.prio != '0) begin
          wr.we_lat = 1'b1;
          wr.addr   = vidx;
          wr.lat    = lat_sat;
        end
        if (pass_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (rem_r == '0) begin
          wr.we_prio = 1'b1;
          wr.addr    = pos;
          wr.prio    = '0;
        end
        state_next = S_IDLE;
      end
      S_NOP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      quantum <= 16'd1;
      vld     <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (quantum_we) quantum <= quantum_wdata;
      if (state == S_ADD && !full) count <= count + CNT_W'(1);
      vld  <= issue;
      done <= (state == S_ADD) || (state == S_READ && read_bad) ||
              (state == S_READ_WAIT) || (state == S_SCAN && pass_end && best == '0) ||
              (state == S_FINISH) || (state == S_NOP);
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    vidx <= ptr[IDX_W-1:0];
    if (issue) ptr <= ptr + CNT_W'(1);
    unique case (state)
      S_IDLE: begin
        ptr  <= '0;
        best <= '0;
        if (start) begin
          cmd_q  <= cmd_t'(cmd);
          id_q   <= proc_id;
          time_q <= run_time;
          prio_q <= prio;
          idx_q  <= entry_index;
        end
      end
      S_ADD: begin
        status        <= full ? ST_FULL : ST_ADDED;
        out_id        <= '0;
        out_remaining <= '0;
        out_latency   <= '0;
      end
      S_READ: begin
        status        <= ST_BADIDX;
        out_id        <= '0;
        out_remaining <= '0;
        out_latency   <= '0;
      end
      S_READ_WAIT: begin
        status        <= ST_READ;
        out_id        <= rd.id;
        out_remaining <= rd.rem;
        out_latency   <= rd.lat;
      end
      S_SCAN: begin
        // strict compare keeps the lowest index on a tie
        if (vld && rd.prio > best && rd.rem != '0) begin
          best <= rd.prio;
          pos  <= vidx;
        end
        status        <= ST_IDLE;
        out_id        <= '0;
        out_remaining <= '0;
        out_latency   <= '0;
      end
      S_FETCH: ;
      S_FETCH_WAIT: begin
        run   <= run_calc;
        id_r  <= rd.id;
        rem_r <= rem_calc;
        ptr   <= '0;
      end
      S_UPDATE: begin
        if (vld && vidx == pos) lat_r <= (rd.prio != '0) ? lat_sat : rd.lat;
      end
      S_FINISH: begin
        status        <= ST_RAN;
        out_id        <= id_r;
        out_remaining <= rem_r;
        out_latency   <= lat_r;
      end
      S_NOP: begin
        status        <= ST_IDLE;
        out_id        <= '0;
        out_remaining <= '0;
        out_latency   <= '0;
      end
      default: ;
    endcase
  end

  // Checks
  `include "priority_quantum_scheduler_core_assert.svh"

  `PQS_ASSERT_IMPL(a_accept_busy, start && !busy, ##1 busy, "accepted beat did not raise busy")
  `PQS_ASSERT_IMPL(a_done_after_busy, done, $past(busy), "result beat without a command")
  `PQS_ASSERT(a_count_range, count <= CNT_W'(MAX_PROCS), "entry count beyond table size")
  `PQS_ASSERT_IMPL(a_empty_fields,
                   done && (status == ST_ADDED || status == ST_FULL || status == ST_IDLE ||
                            status == ST_BADIDX),
                   out_id == '0 && out_remaining == '0 && out_latency == '0,
                   "nonzero fields on an empty result")
  `PQS_ASSERT_IMPL(a_ran_cmd, done && status == ST_RAN, cmd_q == CMD_STEP,
                   "ran status for a command other than step")

endmodule
